>>> rtl/fvc_pkg.sv
// ----------------------------------------------------------------------------
// fvc_pkg
// Types and constants shared by the frame validity checker.
// ----------------------------------------------------------------------------
package fvc_pkg;

    localparam logic [7:0]  PREAMBLE_BYTE = 8'h3F;
    localparam logic [7:0]  START_BYTE    = 8'h68;
    localparam logic [7:0]  END_BYTE      = 8'h16;
    localparam logic [15:0] MIN_LENGTH    = 16'd5;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;

    typedef struct packed {
        logic        start_ok;
        logic        length_ok;
        logic        end_ok;
        logic        checksum_ok;
        logic        frame_valid;
        logic [15:0] frame_length;
    } fvc_result_t;

endpackage

>>> rtl/fvc_in_reg.sv
// ----------------------------------------------------------------------------
// fvc_in_reg
// Input word register; holds one byte until the frame tracker takes it.
// ----------------------------------------------------------------------------
module fvc_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] rx_byte,
    input  logic       buffer_end,
    input  logic       advance,
    output logic       hold_valid,
    output logic [7:0] hold_byte,
    output logic       hold_end
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       take;

    assign byte_stall = vld_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_byte;
            end_reg  <= buffer_end;
        end
    end

    assign hold_valid = vld_reg;
    assign hold_byte  = byte_reg;
    assign hold_end   = end_reg;

endmodule

>>> rtl/fvc_frame_track.sv
// ----------------------------------------------------------------------------
// fvc_frame_track
// Frame state: preamble skip, position count, length field, running sum and
// the start, end and checksum matches. Gives the status on the last byte.
// ----------------------------------------------------------------------------
module fvc_frame_track
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          hold_byte,
    input  logic                hold_end,
    output fvc_pkg::fvc_result_t result
);

    import fvc_pkg::*;

    logic        in_preamble_reg,  in_preamble_next;
    logic [15:0] position_reg,     position_next;
    logic [15:0] length_seen_reg,  length_seen_next;
    logic [7:0]  running_sum_reg,  running_sum_next;
    logic        start_seen_reg,   start_seen_next;
    logic        end_matched_reg,  end_matched_next;
    logic        sum_matched_reg,  sum_matched_next;

    logic        counting;
    logic [16:0] pos_ext;
    logic [16:0] len_ext;
    logic        l_ok;
    logic        e_ok;
    logic        c_ok;

    assign pos_ext  = {1'b0, position_reg};
    assign len_ext  = {1'b0, length_seen_reg};
    assign counting = !(in_preamble_reg && (hold_byte == PREAMBLE_BYTE));

    always_comb
    begin
        in_preamble_next = in_preamble_reg;
        position_next    = position_reg;
        length_seen_next = length_seen_reg;
        running_sum_next = running_sum_reg;
        start_seen_next  = start_seen_reg;
        end_matched_next = end_matched_reg;
        sum_matched_next = sum_matched_reg;
        if (counting)
        begin
            in_preamble_next = 1'b0;
            if (position_reg != POS_MAX)
            begin
                position_next = position_reg + 16'd1;
                case (position_reg)
                    16'd0:
                    begin
                        start_seen_next = (hold_byte == START_BYTE);
                    end
                    16'd1:
                    begin
                        length_seen_next = {length_seen_reg[15:8], hold_byte};
                    end
                    16'd2:
                    begin
                        length_seen_next = {hold_byte, length_seen_reg[7:0]};
                    end
                    default:
                    begin
                        if (length_seen_reg >= MIN_LENGTH)
                        begin
                            if ((pos_ext + 17'd3) <= len_ext)
                            begin
                                running_sum_next = running_sum_reg + hold_byte;
                            end
                            if ((pos_ext + 17'd2) == len_ext)
                            begin
                                sum_matched_next = (hold_byte == running_sum_reg);
                            end
                            if ((pos_ext + 17'd1) == len_ext)
                            begin
                                end_matched_next = (hold_byte == END_BYTE);
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign l_ok = (length_seen_next >= MIN_LENGTH) && (length_seen_next <= position_next);
    assign e_ok = l_ok && end_matched_next;
    assign c_ok = e_ok && sum_matched_next;

    always_comb
    begin
        result.start_ok     = start_seen_next;
        result.length_ok    = l_ok;
        result.end_ok       = e_ok;
        result.checksum_ok  = c_ok;
        result.frame_valid  = start_seen_next && c_ok;
        result.frame_length = length_seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_preamble_reg <= 1'b1;
            position_reg    <= '0;
            length_seen_reg <= '0;
            running_sum_reg <= '0;
            start_seen_reg  <= 1'b0;
            end_matched_reg <= 1'b0;
            sum_matched_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (hold_end)
            begin
                in_preamble_reg <= 1'b1;
                position_reg    <= '0;
                length_seen_reg <= '0;
                running_sum_reg <= '0;
                start_seen_reg  <= 1'b0;
                end_matched_reg <= 1'b0;
                sum_matched_reg <= 1'b0;
            end
            else
            begin
                in_preamble_reg <= in_preamble_next;
                position_reg    <= position_next;
                length_seen_reg <= length_seen_next;
                running_sum_reg <= running_sum_next;
                start_seen_reg  <= start_seen_next;
                end_matched_reg <= end_matched_next;
                sum_matched_reg <= sum_matched_next;
            end
        end
    end

endmodule

>>> rtl/fvc_out_reg.sv
// ----------------------------------------------------------------------------
// fvc_out_reg
// Result register; holds a status word until the consumer takes it.
// ----------------------------------------------------------------------------
module fvc_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  fvc_pkg::fvc_result_t result,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 free,
    output fvc_pkg::fvc_result_t held
);

    import fvc_pkg::*;

    logic        vld_reg;
    logic        vld_next;
    fvc_result_t res_reg;

    assign free = !vld_reg || !result_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (!result_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign result_valid = vld_reg;
    assign held         = res_reg;

endmodule

>>> rtl/frame_validity_checker_top.sv
// ----------------------------------------------------------------------------
// frame_validity_checker_top
// Byte-serial frame check: preamble skip, start byte, length, end byte and
// 8-bit byte-sum checksum; one status word per buffer.
//
//   channel   valid          stall          payload
//   byte      byte_valid     byte_stall     rx_byte, buffer_end
//   result    result_valid   result_stall   start_ok .. frame_length
//
// One byte per cycle unless byte_stall is high; result_valid rises after the
// buffer_end byte is taken (input register, then result register).
// Reset is asynchronous and clears all frame state and both valid flags.
// byte_stall rises only when the result register is full and stalled and the
// registered byte ends a buffer.
// ----------------------------------------------------------------------------
module frame_validity_checker_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rx_byte,
    input  logic        buffer_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        start_ok,
    output logic        length_ok,
    output logic        end_ok,
    output logic        checksum_ok,
    output logic        frame_valid,
    output logic [15:0] frame_length
);

    import fvc_pkg::*;

    logic        hold_valid;
    logic [7:0]  hold_byte;
    logic        hold_end;
    logic        advance;
    logic        out_free;
    fvc_result_t result;
    fvc_result_t held;

    assign advance = hold_valid && (!hold_end || out_free);

    fvc_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .rx_byte    (rx_byte),
        .buffer_end (buffer_end),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte),
        .hold_end   (hold_end)
    );

    fvc_frame_track u_frame_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .hold_byte (hold_byte),
        .hold_end  (hold_end),
        .result    (result)
    );

    fvc_out_reg u_out_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && hold_end),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .free         (out_free),
        .held         (held)
    );

    assign start_ok     = held.start_ok;
    assign length_ok    = held.length_ok;
    assign end_ok       = held.end_ok;
    assign checksum_ok  = held.checksum_ok;
    assign frame_valid  = held.frame_valid;
    assign frame_length = held.frame_length;

endmodule

>>> sim/tb_frame_validity_checker_top.sv
// ----------------------------------------------------------------------------
// tb_frame_validity_checker_top
// Self-checking bench for the byte-serial frame validity checker. Buffers
// are built as byte streams: a directed set of corner frames first, then
// random frames that are mostly well formed with random body content, plus
// corrupted, truncated and noise buffers. A local
// frame tracker predicts each status word, and the monitor compares every
// status word with the oldest prediction. Sender gaps and receiver stalls
// move through idle phases as the run goes on.
// ----------------------------------------------------------------------------
module tb_frame_validity_checker_top;

    timeunit 1ns;
    timeprecision 1ps;

    import fvc_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } byte_word_t;

    typedef logic [7:0] byte_list_t [$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        buffer_end = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        start_ok;
    logic        length_ok;
    logic        end_ok;
    logic        checksum_ok;
    logic        frame_valid;
    logic [15:0] frame_length;

    byte_word_t  pending_words [$];
    fvc_result_t status_expect_q [$];
    int          words_total = 0;
    int          words_accepted = 0;
    int          fail_count = 0;
    bit          byte_taken = 1'b0;
    int          gap_pct;
    int          stall_pct;

    // frame tracker state
    logic        trk_in_preamble = 1'b1;
    logic [15:0] trk_position = '0;
    logic [15:0] trk_length = '0;
    logic [7:0]  trk_sum = '0;
    logic        trk_start_hit = 1'b0;
    logic        trk_end_hit = 1'b0;
    logic        trk_sum_hit = 1'b0;

    frame_validity_checker_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .rx_byte      (rx_byte),
        .buffer_end   (buffer_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .start_ok     (start_ok),
        .length_ok    (length_ok),
        .end_ok       (end_ok),
        .checksum_ok  (checksum_ok),
        .frame_valid  (frame_valid),
        .frame_length (frame_length)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @*
    begin
        case ((words_accepted / 150) % 4)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 54; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 54; end
            default: begin gap_pct = 16; stall_pct = 16; end
        endcase
    end

    task automatic track_word(input logic [7:0] b, input logic last);
        int          p;
        int          len;
        logic        lok;
        logic        eok;
        logic        cok;
        fvc_result_t st;
        len = int'(trk_length);
        if (!(trk_in_preamble && b == PREAMBLE_BYTE))
        begin
            trk_in_preamble = 1'b0;
            p = int'(trk_position);
            if (trk_position != POS_MAX)
            begin
                if (p == 0)
                    trk_start_hit = (b == START_BYTE);
                else if (p == 1)
                    trk_length[7:0] = b;
                else if (p == 2)
                    trk_length[15:8] = b;
                else if (len >= int'(MIN_LENGTH))
                begin
                    if (p + 3 <= len)
                        trk_sum = trk_sum + b;
                    if (p + 2 == len)
                        trk_sum_hit = (b == trk_sum);
                    if (p + 1 == len)
                        trk_end_hit = (b == END_BYTE);
                end
                trk_position = trk_position + 16'd1;
            end
        end
        if (last)
        begin
            lok = (trk_length >= MIN_LENGTH) && (trk_length <= trk_position);
            eok = lok && trk_end_hit;
            cok = eok && trk_sum_hit;
            st.start_ok     = trk_start_hit;
            st.length_ok    = lok;
            st.end_ok       = eok;
            st.checksum_ok  = cok;
            st.frame_valid  = trk_start_hit && lok && eok && cok;
            st.frame_length = trk_length;
            status_expect_q.push_back(st);
            trk_in_preamble = 1'b1;
            trk_position    = '0;
            trk_length      = '0;
            trk_sum         = '0;
            trk_start_hit   = 1'b0;
            trk_end_hit     = 1'b0;
            trk_sum_hit     = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_buffer(input byte_list_t bytes, input bit drain);
        byte_word_t w;
        for (int i = 0; i < bytes.size(); i++)
        begin
            w.data  = bytes[i];
            w.last  = (i == bytes.size() - 1);
            w.drain = drain && (i == 0);
            pending_words.push_back(w);
        end
        words_total += bytes.size();
    endtask

    task automatic build_frame(input int len, input int pre_cnt, input int trail,
                               output byte_list_t bytes);
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] lf;
        bytes = {};
        sum = '0;
        lf = len[15:0];
        repeat (pre_cnt)
            bytes.push_back(PREAMBLE_BYTE);
        bytes.push_back(START_BYTE);
        bytes.push_back(lf[7:0]);
        bytes.push_back(lf[15:8]);
        for (int p = 3; p <= len - 3; p++)
        begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            bytes.push_back(b);
        end
        bytes.push_back(sum);
        bytes.push_back(END_BYTE);
        repeat (trail)
            bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // sender: new word only once the current one is taken
    always @(negedge clk)
    begin : drive_bytes
        byte_word_t w;
        if (!rst_n)
            byte_valid <= 1'b0;
        else
        begin
            if (!byte_valid || byte_taken)
            begin
                if (pending_words.size() != 0 &&
                    !(pending_words[0].drain && status_expect_q.size() != 0) &&
                    $urandom_range(0, 99) >= gap_pct)
                begin
                    w = pending_words.pop_front();
                    byte_valid <= 1'b1;
                    rx_byte    <= w.data;
                    buffer_end <= w.last;
                end
                else
                    byte_valid <= 1'b0;
            end
            byte_taken = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin : watch_status
        fvc_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (status_expect_q.size() == 0)
                begin
                    $error("status word with none expected");
                    fail_count++;
                end
                else
                begin
                    want = status_expect_q.pop_front();
                    check_field("start_ok",     want.start_ok,     start_ok);
                    check_field("length_ok",    want.length_ok,    length_ok);
                    check_field("end_ok",       want.end_ok,       end_ok);
                    check_field("checksum_ok",  want.checksum_ok,  checksum_ok);
                    check_field("frame_valid",  want.frame_valid,  frame_valid);
                    check_field("frame_length", want.frame_length, frame_length);
                end
            end
            if (byte_valid && !byte_stall)
            begin
                track_word(rx_byte, buffer_end);
                byte_taken = 1'b1;
                words_accepted++;
            end
        end
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : run_sequence
        byte_list_t bytes;
        int         random_bytes;
        int         kind;
        int         len;
        int         idx;

        // corner buffers
        bytes = '{8'h3F, 8'h3F, 8'h3F};                      queue_buffer(bytes, 0);
        bytes = '{8'h68};                                    queue_buffer(bytes, 0);
        bytes = '{8'h68, 8'h07};                             queue_buffer(bytes, 0);
        bytes = '{8'h68, 8'h05, 8'h00};                      queue_buffer(bytes, 0);
        bytes = '{8'h68, 8'h04, 8'h00, 8'h00, 8'h16};        queue_buffer(bytes, 0);
        bytes = '{8'h3F, 8'h68, 8'h05, 8'h00, 8'h00, 8'h16}; queue_buffer(bytes, 0);
        bytes = '{8'h69, 8'h05, 8'h00, 8'h00, 8'h16};        queue_buffer(bytes, 0);
        bytes = '{8'h68, 8'h05, 8'h00, 8'h00, 8'h17};        queue_buffer(bytes, 0);
        bytes = '{8'h68, 8'h06, 8'h00, 8'hFF, 8'h00, 8'h16}; queue_buffer(bytes, 0);
        bytes = '{8'h68, 8'h08, 8'h00, 8'hFF, 8'h3F, 8'h00, 8'h3E, 8'h16};
        queue_buffer(bytes, 0);
        bytes = '{8'h68, 8'h20, 8'h00, 8'h01, 8'h16};        queue_buffer(bytes, 0);
        bytes = '{8'h68, 8'h05, 8'h00, 8'h00, 8'h16, 8'hAA, 8'h55};
        queue_buffer(bytes, 0);
        bytes = '{8'h68, 8'h00, 8'h01, 8'h00, 8'h16};        queue_buffer(bytes, 0);
        bytes = '{8'hFF, 8'hFF, 8'hFF};                      queue_buffer(bytes, 0);

        random_bytes = 0;
        while (random_bytes < 640)
        begin
            if ($urandom_range(0, 99) < 3)
                len = $urandom_range(100, 400);
            else
                len = $urandom_range(5, 20);
            build_frame(len, $urandom_range(0, 4),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0, bytes);
            kind = $urandom_range(0, 99);
            if (kind >= 60 && kind < 75)
            begin
                idx = $urandom_range(0, bytes.size() - 1);
                bytes[idx] = bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            else if (kind >= 75 && kind < 85)
                repeat ($urandom_range(1, 3))
                    void'(bytes.pop_back());
            else if (kind >= 85 && kind < 95)
            begin
                bytes = {};
                repeat ($urandom_range(1, 12))
                    bytes.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    bytes[0] = START_BYTE;
            end
            else if (kind >= 95)
            begin
                idx = 0;
                while (bytes[idx] == PREAMBLE_BYTE)
                    idx++;
                bytes[idx + 1] = 8'($urandom_range(0, 255));
                bytes[idx + 2] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'h00;
            end
            queue_buffer(bytes, random_bytes == 0 || $urandom_range(0, 49) == 0);
            random_bytes += bytes.size();
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (words_accepted < words_total)
            @(posedge clk);
        while (status_expect_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
